@@ rtl/ndeftlv_pkg.sv @@
// shared types and constants for the ndef tlv record byte parser
`timescale 1ns / 1ps

package ndeftlv_pkg;

    localparam logic [7:0] TERMINATOR_TAG   = 8'hFE;
    localparam logic [7:0] LONG_LENGTH_MARK = 8'hFF;
    localparam int unsigned HDR_SR_BIT      = 4;
    localparam int unsigned HDR_IL_BIT      = 3;

    typedef enum logic [12:0] {
        PH_TAG     = 13'b0_0000_0000_0001,
        PH_LEN     = 13'b0_0000_0000_0010,
        PH_LEN_HI  = 13'b0_0000_0000_0100,
        PH_LEN_LO  = 13'b0_0000_0000_1000,
        PH_HDR     = 13'b0_0000_0001_0000,
        PH_TYPELEN = 13'b0_0000_0010_0000,
        PH_PAYLEN  = 13'b0_0000_0100_0000,
        PH_IDLEN   = 13'b0_0000_1000_0000,
        PH_TYPE    = 13'b0_0001_0000_0000,
        PH_ID      = 13'b0_0010_0000_0000,
        PH_PAYLOAD = 13'b0_0100_0000_0000,
        PH_SKIP    = 13'b0_1000_0000_0000,
        PH_IGNORE  = 13'b1_0000_0000_0000
    } phase_t;

    typedef enum logic [3:0] {
        ROLE_TAG     = 4'd0,
        ROLE_LENGTH  = 4'd1,
        ROLE_HEADER  = 4'd2,
        ROLE_TYPELEN = 4'd3,
        ROLE_PAYLEN  = 4'd4,
        ROLE_IDLEN   = 4'd5,
        ROLE_TYPE    = 4'd6,
        ROLE_ID      = 4'd7,
        ROLE_PAYLOAD = 4'd8,
        ROLE_TERM    = 4'd9,
        ROLE_IGNORED = 4'd10,
        ROLE_UNSUP   = 4'd11
    } role_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } in_word_t;

    typedef struct packed {
        role_t       byte_role;
        logic [7:0]  field_position;
        logic        field_last;
        logic [15:0] tlv_value_length;
        logic [7:0]  record_type_length;
        logic [7:0]  record_payload_length;
        logic [7:0]  record_id_length;
    } out_word_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] tlv_bytes_left;
        logic [7:0]  length_high_byte;
        logic [7:0]  field_bytes_left;
        logic [7:0]  field_index;
        logic [7:0]  type_len;
        logic [7:0]  payload_len;
        logic [7:0]  id_len;
        logic        id_present;
        logic [15:0] tlv_length;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:            PH_TAG,
        tlv_bytes_left:   16'd0,
        length_high_byte: 8'd0,
        field_bytes_left: 8'd0,
        field_index:      8'd0,
        type_len:         8'd0,
        payload_len:      8'd0,
        id_len:           8'd0,
        id_present:       1'b0,
        tlv_length:       16'd0
    };

endpackage

@@ rtl/ndef_tlv_record_byte_parser.sv @@
// top level of the ndef tlv record byte parser
//
// takes a tag memory image one byte per word on the byte channel and
// returns one word per byte on the role channel: the byte's role, its
// position within a type, id or payload field, an end-of-field flag and
// the tlv and short record lengths decoded so far.
// both channels use valid and stall; a word moves on a clock edge with
// valid high and stall low.
// latency: the role word for a byte appears the cycle after that byte is
// taken. throughput: one byte per cycle, set by the single parse state
// register, which is updated from the incoming byte in the same cycle.
// the role word sits in an output register; while the receiver stalls,
// that register holds and the byte channel is stalled, otherwise a new
// byte is taken every cycle even as the previous word is handed over.
// a byte flagged buffer_last returns the parse state to its reset value
// once its role word has been formed.
// reset clears the parse state to expect a tlv tag and empties the
// output register.
`timescale 1ns / 1ps

module ndef_tlv_record_byte_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  ndeftlv_pkg::in_word_t  byte_word,
    output logic                   role_valid,
    input  logic                   role_stall,
    output ndeftlv_pkg::out_word_t role_word
);

    ndeftlv_pkg::parse_state_t state_reg;
    ndeftlv_pkg::parse_state_t state_next;
    ndeftlv_pkg::parse_state_t step_state;
    ndeftlv_pkg::out_word_t    step_out;
    ndeftlv_pkg::out_word_t    out_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      accept;

    ndeftlv_step u_step
    (
        .cur      (state_reg),
        .in_word  (byte_word),
        .nxt      (step_state),
        .out_word (step_out)
    );

    assign byte_stall     = out_valid_reg & role_stall;
    assign accept         = byte_valid & ~byte_stall;
    assign out_valid_next = accept | (out_valid_reg & role_stall);
    assign state_next     = byte_word.buffer_last ? ndeftlv_pkg::STATE_RESET : step_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ndeftlv_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= step_out;
        end
    end

    assign role_valid = out_valid_reg;
    assign role_word  = out_reg;

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg.phase))
        else $error("parse phase not one-hot");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_word.buffer_last |=> state_reg.phase == ndeftlv_pkg::PH_TAG)
        else $error("buffer end did not restart parsing");

    a_after_term: assert property (@(posedge clk) disable iff (!rst_n)
        accept && state_reg.phase == ndeftlv_pkg::PH_IGNORE
        |=> role_valid && role_word.byte_role == ndeftlv_pkg::ROLE_IGNORED)
        else $error("byte after terminator not ignored");

    a_position_field: assert property (@(posedge clk) disable iff (!rst_n)
        role_valid && role_word.field_position != 8'd0
        |-> role_word.byte_role == ndeftlv_pkg::ROLE_TYPE
            || role_word.byte_role == ndeftlv_pkg::ROLE_ID
            || role_word.byte_role == ndeftlv_pkg::ROLE_PAYLOAD)
        else $error("field position outside a body field");

    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> role_valid)
        else $error("accepted byte produced no role word");

endmodule

@@ rtl/ndeftlv_step.sv @@
// next parse state and byte label for one tag memory byte
`timescale 1ns / 1ps

module ndeftlv_step
(
    input  ndeftlv_pkg::parse_state_t cur,
    input  ndeftlv_pkg::in_word_t     in_word,
    output ndeftlv_pkg::parse_state_t nxt,
    output ndeftlv_pkg::out_word_t    out_word
);

    localparam logic [1:0] STAGE_TYPE    = 2'd0;
    localparam logic [1:0] STAGE_ID      = 2'd1;
    localparam logic [1:0] STAGE_PAYLOAD = 2'd2;
    localparam logic [1:0] STAGE_DONE    = 2'd3;

    // first non-empty body field at or after the given stage, else the next record header
    function automatic ndeftlv_pkg::phase_t enter_phase(
        input logic [1:0] stage,
        input logic [7:0] tl,
        input logic [7:0] il,
        input logic [7:0] pl
    );
        ndeftlv_pkg::phase_t ph;
        priority if (stage == STAGE_TYPE && tl != 8'd0)
            ph = ndeftlv_pkg::PH_TYPE;
        else if (stage <= STAGE_ID && il != 8'd0)
            ph = ndeftlv_pkg::PH_ID;
        else if (stage <= STAGE_PAYLOAD && pl != 8'd0)
            ph = ndeftlv_pkg::PH_PAYLOAD;
        else
            ph = ndeftlv_pkg::PH_HDR;
        return ph;
    endfunction

    function automatic logic [7:0] enter_count(
        input ndeftlv_pkg::phase_t ph,
        input logic [7:0] tl,
        input logic [7:0] il,
        input logic [7:0] pl
    );
        logic [7:0] cnt;
        unique case (ph)
            ndeftlv_pkg::PH_TYPE:    cnt = tl;
            ndeftlv_pkg::PH_ID:      cnt = il;
            ndeftlv_pkg::PH_PAYLOAD: cnt = pl;
            default:                 cnt = 8'd0;
        endcase
        return cnt;
    endfunction

    logic [7:0]          b;
    logic                value_byte;
    logic [7:0]          fbl_dec;
    logic [15:0]         tbl_dec;
    logic [1:0]          next_stage;
    ndeftlv_pkg::phase_t entered;

    assign b       = in_word.data_byte;
    assign fbl_dec = cur.field_bytes_left - 8'd1;

    always_comb
    begin
        nxt                     = cur;
        value_byte              = 1'b0;
        next_stage              = STAGE_DONE;
        entered                 = ndeftlv_pkg::PH_HDR;
        tbl_dec                 = 16'd0;
        out_word.byte_role      = ndeftlv_pkg::ROLE_IGNORED;
        out_word.field_position = 8'd0;
        out_word.field_last     = 1'b0;

        unique case (cur.phase)
            ndeftlv_pkg::PH_TAG:
            begin
                nxt.type_len    = 8'd0;
                nxt.payload_len = 8'd0;
                nxt.id_len      = 8'd0;
                nxt.id_present  = 1'b0;
                nxt.tlv_length  = 16'd0;
                if (b == ndeftlv_pkg::TERMINATOR_TAG)
                begin
                    out_word.byte_role = ndeftlv_pkg::ROLE_TERM;
                    nxt.phase          = ndeftlv_pkg::PH_IGNORE;
                end
                else
                begin
                    out_word.byte_role = ndeftlv_pkg::ROLE_TAG;
                    nxt.phase          = ndeftlv_pkg::PH_LEN;
                end
            end
            ndeftlv_pkg::PH_LEN:
            begin
                out_word.byte_role = ndeftlv_pkg::ROLE_LENGTH;
                if (b == ndeftlv_pkg::LONG_LENGTH_MARK)
                begin
                    nxt.phase = ndeftlv_pkg::PH_LEN_HI;
                end
                else
                begin
                    nxt.tlv_length     = {8'd0, b};
                    nxt.tlv_bytes_left = {8'd0, b};
                    if (b == 8'd0)
                    begin
                        out_word.field_last = 1'b1;
                        nxt.phase           = ndeftlv_pkg::PH_TAG;
                    end
                    else
                    begin
                        nxt.phase = ndeftlv_pkg::PH_HDR;
                    end
                end
            end
            ndeftlv_pkg::PH_LEN_HI:
            begin
                out_word.byte_role   = ndeftlv_pkg::ROLE_LENGTH;
                nxt.length_high_byte = b;
                nxt.tlv_length       = {b, 8'd0};
                nxt.phase            = ndeftlv_pkg::PH_LEN_LO;
            end
            ndeftlv_pkg::PH_LEN_LO:
            begin
                out_word.byte_role = ndeftlv_pkg::ROLE_LENGTH;
                nxt.tlv_length     = {cur.length_high_byte, b};
                nxt.tlv_bytes_left = {cur.length_high_byte, b};
                if ({cur.length_high_byte, b} == 16'd0)
                begin
                    out_word.field_last = 1'b1;
                    nxt.phase           = ndeftlv_pkg::PH_TAG;
                end
                else
                begin
                    nxt.phase = ndeftlv_pkg::PH_HDR;
                end
            end
            ndeftlv_pkg::PH_HDR:
            begin
                value_byte      = 1'b1;
                nxt.type_len    = 8'd0;
                nxt.payload_len = 8'd0;
                nxt.id_len      = 8'd0;
                if (b[ndeftlv_pkg::HDR_SR_BIT])
                begin
                    out_word.byte_role = ndeftlv_pkg::ROLE_HEADER;
                    nxt.id_present     = b[ndeftlv_pkg::HDR_IL_BIT];
                    nxt.phase          = ndeftlv_pkg::PH_TYPELEN;
                end
                else
                begin
                    // long record: rest of the tlv value is skipped
                    out_word.byte_role = ndeftlv_pkg::ROLE_UNSUP;
                    nxt.id_present     = 1'b0;
                    nxt.phase          = ndeftlv_pkg::PH_SKIP;
                end
            end
            ndeftlv_pkg::PH_TYPELEN:
            begin
                value_byte         = 1'b1;
                out_word.byte_role = ndeftlv_pkg::ROLE_TYPELEN;
                nxt.type_len       = b;
                nxt.phase          = ndeftlv_pkg::PH_PAYLEN;
            end
            ndeftlv_pkg::PH_PAYLEN:
            begin
                value_byte         = 1'b1;
                out_word.byte_role = ndeftlv_pkg::ROLE_PAYLEN;
                nxt.payload_len    = b;
                if (cur.id_present)
                begin
                    nxt.phase = ndeftlv_pkg::PH_IDLEN;
                end
                else
                begin
                    nxt.id_len           = 8'd0;
                    entered              = enter_phase(STAGE_TYPE, cur.type_len, 8'd0, b);
                    nxt.phase            = entered;
                    nxt.field_index      = 8'd0;
                    nxt.field_bytes_left = enter_count(entered, cur.type_len, 8'd0, b);
                end
            end
            ndeftlv_pkg::PH_IDLEN:
            begin
                value_byte           = 1'b1;
                out_word.byte_role   = ndeftlv_pkg::ROLE_IDLEN;
                nxt.id_len           = b;
                entered              = enter_phase(STAGE_TYPE, cur.type_len, b,
                                                   cur.payload_len);
                nxt.phase            = entered;
                nxt.field_index      = 8'd0;
                nxt.field_bytes_left = enter_count(entered, cur.type_len, b,
                                                   cur.payload_len);
            end
            ndeftlv_pkg::PH_TYPE, ndeftlv_pkg::PH_ID, ndeftlv_pkg::PH_PAYLOAD:
            begin
                value_byte = 1'b1;
                unique case (cur.phase)
                    ndeftlv_pkg::PH_TYPE:
                    begin
                        out_word.byte_role = ndeftlv_pkg::ROLE_TYPE;
                        next_stage         = STAGE_ID;
                    end
                    ndeftlv_pkg::PH_ID:
                    begin
                        out_word.byte_role = ndeftlv_pkg::ROLE_ID;
                        next_stage         = STAGE_PAYLOAD;
                    end
                    default:
                    begin
                        out_word.byte_role = ndeftlv_pkg::ROLE_PAYLOAD;
                        next_stage         = STAGE_DONE;
                    end
                endcase
                out_word.field_position = cur.field_index;
                nxt.field_index         = cur.field_index + 8'd1;
                nxt.field_bytes_left    = fbl_dec;
                if (fbl_dec == 8'd0)
                begin
                    out_word.field_last  = 1'b1;
                    entered              = enter_phase(next_stage, cur.type_len,
                                                       cur.id_len, cur.payload_len);
                    nxt.phase            = entered;
                    nxt.field_index      = 8'd0;
                    nxt.field_bytes_left = enter_count(entered, cur.type_len,
                                                       cur.id_len, cur.payload_len);
                end
            end
            ndeftlv_pkg::PH_SKIP:
            begin
                value_byte         = 1'b1;
                out_word.byte_role = ndeftlv_pkg::ROLE_UNSUP;
            end
            default:
            begin
                out_word.byte_role = ndeftlv_pkg::ROLE_IGNORED;
                nxt.phase          = ndeftlv_pkg::PH_IGNORE;
            end
        endcase

        // every byte inside a tlv value counts down the tlv length
        if (value_byte)
        begin
            tbl_dec            = cur.tlv_bytes_left - 16'd1;
            nxt.tlv_bytes_left = tbl_dec;
            if (tbl_dec == 16'd0)
            begin
                out_word.field_last = 1'b1;
                nxt.phase           = ndeftlv_pkg::PH_TAG;
            end
        end

        out_word.tlv_value_length      = nxt.tlv_length;
        out_word.record_type_length    = nxt.type_len;
        out_word.record_payload_length = nxt.payload_len;
        out_word.record_id_length      = nxt.id_len;
    end

endmodule
